>>> design/htw_pkg.sv
// Package for the hashed timing wheel: widths, codes, cell and control types.
// Used by htw_cell, the top level and the testbench.
package htw_pkg;

  localparam int MaxTimersDef = 32;
  localparam int MaxSlotsDef  = 256;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_NEG     = 3'd1,
    ST_FULL    = 3'd2,
    ST_DELETED = 3'd3,
    ST_UNUSED  = 3'd4,
    ST_EXPIRED = 3'd5,
    ST_DONE    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DIV1,
    FSM_DIV2,
    FSM_MOD,
    FSM_WRITE,
    FSM_SCAN,
    FSM_OUT
  } fsm_t;

  localparam logic CFG_TICK_INTERVAL = 1'b0;
  localparam logic CFG_SLOT_COUNT    = 1'b1;

  // One cell's command from the controller.
  typedef struct packed {
    logic       scan;     // step the scan: tick cells that match and shift token
    logic       start;    // load token into cell 0
    logic [7:0] scan_slot;
  } cell_ctl_t;

endpackage

>>> design/htw_if.sv
// Valid/ready stream interfaces for the timing wheel channels.
// Depends on nothing.
interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] timeout;
  logic [4:0]  handle_in;
  modport source (output valid, kind, timeout, handle_in, input ready);
  modport sink   (input valid, kind, timeout, handle_in, output ready);
endinterface

interface htw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] handle_out;
  logic [7:0] slot;
  logic       last;
  modport source (output valid, status, handle_out, slot, last, input ready);
  modport sink   (input valid, status, handle_out, slot, last, output ready);
endinterface

>>> design/htw_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its own ports.
module htw_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    trial = {r_r, q_r[W-1]};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor; cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = W'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quotient = q_r;
  assign remainder = r_r;
endmodule

>>> design/htw_cell.sv
// One timer cell: valid bit, slot and rotation, plus a scan token stage.
// Depends on htw_pkg.
module htw_cell
  import htw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic       tok_in,
  output logic       tok_out,
  input  logic       wr_en,
  input  logic [7:0] wr_slot,
  input  logic [30:0] wr_rot,
  input  logic       del_en,
  output logic       valid,
  output logic       fire
);
  logic valid_r, valid_nxt, tok_r, tok_nxt;
  logic [7:0] slot_r;
  logic [30:0] rot_r, rot_nxt;
  logic hit;

  assign hit  = tok_r && valid_r && (slot_r == ctl.scan_slot);
  assign fire = hit && (rot_r == '0);

  always_comb begin
    valid_nxt = valid_r; rot_nxt = rot_r; tok_nxt = tok_r;
    if (ctl.scan) begin
      tok_nxt = tok_in;
      if (hit) begin
        if (rot_r != '0) rot_nxt = rot_r - 1'b1;
        else valid_nxt = 1'b0;
      end
    end
    if (wr_en) begin
      valid_nxt = 1'b1; rot_nxt = wr_rot;
    end
    if (del_en) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0; tok_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt; tok_r <= tok_nxt;
    end
    rot_r <= rot_nxt;
    if (wr_en) slot_r <= wr_slot;
  end

  assign tok_out = tok_r;
  assign valid = valid_r;
endmodule

>>> design/hashed_timing_wheel.sv
// Top level of the hashed timing wheel with rotation counts.
// Depends on htw_pkg, htw_if, htw_divider and htw_cell.
//
// Usage:
//  in  : valid/ready transfer of {kind, timeout, handle_in}. kind 0 adds a
//        timer, 1 deletes a handle, 2 ticks the wheel, 3 is dropped.
//  out : valid/ready transfer of {status, handle_out, slot, last}; last marks
//        the final result of one input item.
//  cfg : write port, index 0 tick_interval, index 1 slot_count.
// Timers live in a row of MAX_TIMERS cells. A tick passes a one-hot token
// down the row, one cell per cycle; each cell hit by the token counts its
// rotation down or expires. An expiry halts the token until the result
// register has room, so expiries leave in ascending handle order.
// Delete and rejected add give a registered result; add runs three 32-step
// divisions in the shared divider (timeout by interval, ticks by slot count,
// then current slot plus remainder by slot count); a tick gives the done
// result once the token has left the row and the divider has wrapped the
// current slot. Expiries do not hold the scan while the receiver is ready.
// One item at a time: the input is ready only while idle with no result held.
// Reset: all timers invalid, current slot 0, interval 1, slot count 256.
// A stalled receiver holds the result register and halts the scan at an expiry.
module hashed_timing_wheel
  import htw_pkg::*;
#(
  parameter int MAX_TIMERS = MaxTimersDef,
  parameter int MAX_SLOTS  = MaxSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  htw_in_if.sink      in_ch,
  htw_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int HW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  fsm_t state_r, state_nxt;
  logic [15:0] ival_r;
  logic [8:0]  scnt_r;
  logic [7:0]  cur_r, cur_nxt;
  logic [31:0] ticks_r, ticks_nxt, tout_r, tout_nxt;
  logic [HW-1:0] free_r, free_nxt;

  // result register
  logic ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [4:0] oh_r, oh_nxt;
  logic [7:0] osl_r, osl_nxt;

  // effective slot count
  logic [8:0] neff;
  always_comb begin
    neff = scnt_r;
    if (neff == '0) neff = 9'd1;
    if (neff > 9'(MAX_SLOTS)) neff = 9'(MAX_SLOTS);
  end

  // divider
  logic dv_start, dv_busy;
  logic [31:0] dv_a, dv_b, dv_q, dv_r;
  htw_divider #(.W(32)) u_div (
    .clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quotient(dv_q), .remainder(dv_r));

  // cell row
  cell_ctl_t ctl;
  logic [MAX_TIMERS-1:0] tok, vld, fire, wr_en, del_en;
  logic [7:0]  wr_slot;
  logic [30:0] wr_rot;

  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    htw_cell u_cell (
      .clk, .rst_n, .ctl,
      .tok_in((g == 0) ? ctl.start : tok[(g == 0) ? 0 : g-1]),
      .tok_out(tok[g]), .wr_en(wr_en[g]), .wr_slot, .wr_rot,
      .del_en(del_en[g]), .valid(vld[g]), .fire(fire[g]));
  end

  // lowest free handle
  logic any_free;
  logic [HW-1:0] free_idx;
  always_comb begin
    any_free = 1'b0; free_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        any_free = 1'b1; free_idx = HW'(i);
      end
    end
  end

  // cell holding the token that fires
  logic any_fire;
  logic [HW-1:0] fire_idx;
  always_comb begin
    any_fire = 1'b0; fire_idx = '0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (fire[i]) begin
        any_fire = 1'b1; fire_idx = HW'(i);
      end
    end
  end

  logic in_fire, out_free;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == FSM_IDLE) && !ov_r;
  assign in_fire = in_ch.valid && in_ch.ready;

  // current slot may sit at or above the count, so reduce the sum by division
  logic [8:0] slot_sum;
  assign slot_sum = {1'b0, cur_r} + dv_r[8:0];
  assign wr_slot = dv_r[7:0];
  assign wr_rot  = ticks_r[30:0];

  always_comb begin
    state_nxt = state_r; cur_nxt = cur_r; ticks_nxt = ticks_r;
    tout_nxt = tout_r; free_nxt = free_r;
    ov_nxt = ov_r && !out_ch.ready;
    ost_nxt = ost_r; oh_nxt = oh_r; osl_nxt = osl_r; olast_nxt = olast_r;
    dv_start = 1'b0; dv_a = tout_r;
    dv_b = (ival_r == '0) ? 32'd1 : {16'd0, ival_r};
    ctl.scan = 1'b0; ctl.start = 1'b0; ctl.scan_slot = cur_r;
    wr_en = '0; del_en = '0;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          tout_nxt = in_ch.timeout;
          free_nxt = free_idx;
          case (kind_t'(in_ch.kind))
            KIND_ADD: begin
              if (in_ch.timeout[31]) begin
                ov_nxt = 1'b1; ost_nxt = ST_NEG; oh_nxt = '0; osl_nxt = '0;
                olast_nxt = 1'b1;
              end else if (!any_free) begin
                ov_nxt = 1'b1; ost_nxt = ST_FULL; oh_nxt = '0; osl_nxt = '0;
                olast_nxt = 1'b1;
              end else begin
                dv_start = 1'b1; dv_a = in_ch.timeout;
                state_nxt = FSM_DIV1;
              end
            end
            KIND_DEL: begin
              ov_nxt = 1'b1; oh_nxt = in_ch.handle_in; osl_nxt = '0;
              olast_nxt = 1'b1; ost_nxt = ST_UNUSED;
              for (int i = 0; i < MAX_TIMERS; i++) begin
                if (in_ch.handle_in == 5'(i) && vld[i]) begin
                  ost_nxt = ST_DELETED; del_en[i] = 1'b1;
                end
              end
            end
            KIND_TICK: begin
              ctl.start = 1'b1; ctl.scan = 1'b1; state_nxt = FSM_SCAN;
              // wrap the next slot in the divider while the scan runs
              dv_start = 1'b1; dv_a = {23'd0, {1'b0, cur_r} + 9'd1};
              dv_b = {23'd0, neff};
            end
            default: ;
          endcase
        end
      end
      FSM_DIV1: begin
        if (!dv_busy) begin
          ticks_nxt = (dv_q == '0) ? 32'd1 : dv_q;
          state_nxt = FSM_DIV2;
        end
      end
      FSM_DIV2: begin
        dv_start = 1'b1; dv_a = ticks_r; dv_b = {23'd0, neff};
        state_nxt = FSM_MOD;
      end
      FSM_MOD: begin
        // keep the rotation in ticks_r, then reduce the slot sum
        if (!dv_busy) begin
          ticks_nxt = dv_q;
          dv_start = 1'b1; dv_a = {23'd0, slot_sum}; dv_b = {23'd0, neff};
          state_nxt = FSM_WRITE;
        end
      end
      FSM_WRITE: begin
        if (!dv_busy) begin
          for (int i = 0; i < MAX_TIMERS; i++)
            if (free_r == HW'(i)) wr_en[i] = 1'b1;
          ov_nxt = 1'b1; ost_nxt = ST_ADDED; oh_nxt = 5'(free_r);
          osl_nxt = wr_slot; olast_nxt = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      FSM_SCAN: begin
        // hold the token on an expiry until the result register frees up
        if (!any_fire || out_free) begin
          ctl.scan = 1'b1;
          if (any_fire) begin
            ov_nxt = 1'b1; ost_nxt = ST_EXPIRED; oh_nxt = 5'(fire_idx);
            osl_nxt = cur_r; olast_nxt = 1'b0;
          end
          if (tok[MAX_TIMERS-1]) state_nxt = FSM_OUT;
        end
      end
      FSM_OUT: begin
        if (out_free && !dv_busy) begin
          ov_nxt = 1'b1; ost_nxt = ST_DONE; oh_nxt = '0; osl_nxt = cur_r;
          olast_nxt = 1'b1;
          cur_nxt = dv_r[7:0];
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE; cur_r <= '0; ival_r <= 16'd1; scnt_r <= 9'd256;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cur_r <= cur_nxt; ov_r <= ov_nxt;
      if (cfg_we && cfg_index == CFG_TICK_INTERVAL) ival_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_SLOT_COUNT) scnt_r <= cfg_data[8:0];
    end
    ticks_r <= ticks_nxt; tout_r <= tout_nxt; free_r <= free_nxt;
    ost_r <= ost_nxt; oh_r <= oh_nxt; osl_r <= osl_nxt; olast_r <= olast_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.status = ost_r;
  assign out_ch.handle_out = oh_r;
  assign out_ch.slot = osl_r;
  assign out_ch.last = olast_r;

  // at most one cell holds the scan token
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok)) else $error("scan token not one-hot");
  // no new item is taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !ov_r) else $error("item taken with result pending");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(ost_r) && $stable(oh_r))
    else $error("stalled result changed");
endmodule

>>> test/hashed_timing_wheel_tb.sv
// Testbench for hashed_timing_wheel: directed and random add/delete/tick traffic,
// each result checked against an in-bench model of the wheel.
// Depends on htw_pkg, htw_if and the design files.
module hashed_timing_wheel_tb;
  import htw_pkg::*;

  localparam int NumTimers  = 32;
  localparam int NumSlots   = 256;
  localparam int IdleLimit  = 4000;  // cycles without any transfer
  localparam int SettleWait = 100;   // idle cycles before a register write
  localparam int RandItems  = 315;

  typedef struct {
    status_t    status;
    logic [4:0] handle;
    logic [7:0] slot;
    logic       last;
  } wheel_result_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  htw_in_if  in_ch ();
  htw_out_if out_ch ();

  hashed_timing_wheel u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Wheel model state, mirrored from the block's registers.
  logic [15:0] tick_interval;
  logic [8:0]  wheel_size;
  logic        timer_valid [NumTimers];
  logic [7:0]  timer_slot [NumTimers];
  logic [30:0] timer_rotation [NumTimers];
  logic [7:0]  wheel_pos;

  wheel_result_t pending_results[$];
  int err_count;
  int idle_cycles;
  int burst_left;
  int stall_mode;
  int stall_timer;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Add a result to the list the block still owes.
  task automatic owe(status_t st, logic [4:0] h, logic [7:0] sl, logic lst);
    wheel_result_t r;
    r.status = st;
    r.handle = h;
    r.slot   = sl;
    r.last   = lst;
    pending_results.push_back(r);
  endtask

  // Apply one accepted item to the wheel model and owe its results.
  task automatic advance_wheel(kind_t k, logic [31:0] tmo, logic [4:0] h);
    logic [31:0] n;
    logic [31:0] iv;
    logic [31:0] ticks;
    logic [7:0]  s;
    int free_h;
    n = (wheel_size == 0) ? 1 : (wheel_size > NumSlots) ? NumSlots : wheel_size;
    case (k)
      KIND_ADD: begin
        free_h = -1;
        for (int i = NumTimers - 1; i >= 0; i--) if (!timer_valid[i]) free_h = i;
        if (tmo[31]) begin
          owe(ST_NEG, '0, '0, 1'b1);
        end else if (free_h < 0) begin
          owe(ST_FULL, '0, '0, 1'b1);
        end else begin
          iv    = (tick_interval == 0) ? 1 : tick_interval;
          ticks = tmo / iv;
          if (ticks == 0) ticks = 1;
          s = 8'((wheel_pos + ticks % n) % n);
          timer_valid[free_h]    = 1'b1;
          timer_slot[free_h]     = s;
          timer_rotation[free_h] = 31'(ticks / n);
          owe(ST_ADDED, 5'(free_h), s, 1'b1);
        end
      end
      KIND_DEL: begin
        if (timer_valid[h]) begin
          timer_valid[h] = 1'b0;
          owe(ST_DELETED, h, '0, 1'b1);
        end else begin
          owe(ST_UNUSED, h, '0, 1'b1);
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < NumTimers; i++) begin
          if (timer_valid[i] && timer_slot[i] == wheel_pos) begin
            if (timer_rotation[i] != 0) begin
              timer_rotation[i] = timer_rotation[i] - 1;
            end else begin
              timer_valid[i] = 1'b0;
              owe(ST_EXPIRED, 5'(i), wheel_pos, 1'b0);
            end
          end
        end
        owe(ST_DONE, '0, wheel_pos, 1'b1);
        wheel_pos = 8'((wheel_pos + 1) % n);
      end
      default: ;  // unknown kind: drop, nothing owed
    endcase
  endtask

  // Present one item, hold it until the transfer, then maybe open a gap.
  task automatic send_item(kind_t k, logic [31:0] tmo, logic [4:0] h);
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.timeout   <= tmo;
    in_ch.handle_in <= h;
    do @(posedge clk); while (!in_ch.ready);
    advance_wheel(k, tmo, h);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid, let the block drain and settle so a register write is safe.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICK_INTERVAL) tick_interval = val;
    else wheel_size = val[8:0];
  endtask

  // Add/reject/delete/tick basics under reset settings, plus a dropped kind.
  task automatic test_basic_ops();
    send_item(KIND_ADD, 32'd0, '0);           // zero timeout still takes one tick
    send_item(KIND_ADD, 32'h7FFF_FFFF, '0);   // largest timeout
    send_item(KIND_ADD, 32'h8000_0000, '0);   // most negative: rejected
    send_item(KIND_ADD, 32'hFFFF_FFFF, '0);   // minus one: rejected
    send_item(KIND_DEL, '0, 5'd31);           // never used
    send_item(KIND_NONE, 32'hFFFF_FFFF, 5'd31);
    send_item(KIND_TICK, '0, '0);             // slot 0: nothing due
    send_item(KIND_TICK, '0, '0);             // slot 1: handle 0 expires
    send_item(KIND_DEL, '0, 5'd1);            // free the long timer
    send_item(KIND_DEL, '0, 5'd1);            // now unused
  endtask

  // Fill every handle, overflow, and expire several timers in one tick.
  task automatic test_table_full();
    write_reg(CFG_SLOT_COUNT, 16'd2);
    for (int i = 0; i < NumTimers; i++) send_item(KIND_ADD, 32'(i % 3), '0);
    send_item(KIND_ADD, 32'd5, '0);
    for (int i = 0; i < 4; i++) send_item(KIND_TICK, '0, '0);
    for (int i = 0; i < NumTimers; i++) send_item(KIND_DEL, '0, 5'(i));
  endtask

  // Register extremes, including the zero and out-of-range encodings.
  task automatic test_reg_extremes();
    write_reg(CFG_TICK_INTERVAL, 16'd0);
    write_reg(CFG_SLOT_COUNT, 16'd0);
    send_item(KIND_ADD, 32'd3, '0);
    send_item(KIND_TICK, '0, '0);
    write_reg(CFG_SLOT_COUNT, 16'hFFFF);      // clamps to the full wheel
    write_reg(CFG_TICK_INTERVAL, 16'hFFFF);
    send_item(KIND_ADD, 32'd200000, '0);
    send_item(KIND_ADD, 32'd65534, '0);
    send_item(KIND_TICK, '0, '0);
    send_item(KIND_DEL, '0, 5'd0);
    send_item(KIND_DEL, '0, 5'd1);
    send_item(KIND_DEL, '0, 5'd2);
  endtask

  // Shrink the wheel under live timers and a position past the new count.
  task automatic test_stale_slots();
    write_reg(CFG_TICK_INTERVAL, 16'd1);
    write_reg(CFG_SLOT_COUNT, 16'd256);
    send_item(KIND_ADD, 32'd5, '0);
    send_item(KIND_ADD, 32'd200, '0);
    for (int i = 0; i < 8; i++) send_item(KIND_TICK, '0, '0);
    write_reg(CFG_SLOT_COUNT, 16'd4);
    for (int i = 0; i < 6; i++) send_item(KIND_TICK, '0, '0);
    for (int i = 0; i < 3; i++) send_item(KIND_DEL, '0, 5'(i));
  endtask

  // Random traffic over several wheel settings, mostly small wheels.
  task automatic test_random_traffic();
    int sent;
    int pick;
    int span;
    logic [31:0] tmo;
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TICK_INTERVAL, 16'd1); write_reg(CFG_SLOT_COUNT, 16'd1); end
        1: begin write_reg(CFG_TICK_INTERVAL, 16'd3); write_reg(CFG_SLOT_COUNT, 16'd4); end
        2: begin
          write_reg(CFG_TICK_INTERVAL, 16'($urandom_range(1, 20)));
          write_reg(CFG_SLOT_COUNT, 16'($urandom_range(1, 16)));
        end
        3: begin write_reg(CFG_TICK_INTERVAL, 16'd65535); write_reg(CFG_SLOT_COUNT, 16'd8); end
        default: begin write_reg(CFG_TICK_INTERVAL, 16'd7); write_reg(CFG_SLOT_COUNT, 16'd256); end
      endcase
      span = ((tick_interval == 0) ? 1 : tick_interval) * 3 *
             ((wheel_size == 0) ? 1 : (wheel_size > NumSlots) ? NumSlots : wheel_size);
      while (sent < (ph + 1) * RandItems / 5) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          tmo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span);
          send_item(KIND_ADD, tmo, 5'($urandom));
          sent++;
        end else if (pick < 52) begin
          send_item(KIND_DEL, $urandom,
                    ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom));
          sent++;
        end else if (pick < 96) begin
          send_item(KIND_TICK, $urandom, 5'($urandom));
          sent++;
        end else begin
          send_item(KIND_NONE, $urandom, 5'($urandom));
        end
      end
    end
  endtask

  // Check each result transfer against the oldest owed result.
  always @(posedge clk) begin
    wheel_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d handle %0d slot %0d last %0d",
               out_ch.status, out_ch.handle_out, out_ch.slot, out_ch.last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          err_count++;
        end
        if (out_ch.handle_out !== want.handle) begin
          $error("handle_out: expected %0d, got %0d", want.handle, out_ch.handle_out);
          err_count++;
        end
        if (out_ch.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
          err_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          err_count++;
        end
      end
    end
  end

  // Receiver stalls: switch between always ready, light and heavy stalling.
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(16, 96);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("hashed_timing_wheel_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    err_count   = 0;
    burst_left  = 0;
    tick_interval = 16'd1;
    wheel_size    = 9'd256;
    wheel_pos     = '0;
    for (int i = 0; i < NumTimers; i++) begin
      timer_valid[i]    = 1'b0;
      timer_slot[i]     = '0;
      timer_rotation[i] = '0;
    end
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= 1'b0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_NONE;
    in_ch.timeout   <= '0;
    in_ch.handle_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_table_full();
    test_reg_extremes();
    test_stale_slots();
    test_random_traffic();

    wait_quiet();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("hashed_timing_wheel_tb: done, clean");
    end else begin
      $display("hashed_timing_wheel_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> hashed_timing_wheel.f
design/htw_pkg.sv
design/htw_if.sv
design/htw_divider.sv
design/htw_cell.sv
design/hashed_timing_wheel.sv
test/hashed_timing_wheel_tb.sv
